### rtl/color_space_converter_macros.svh
// Assertion macros shared by the color space converter RTL.
// Needs nothing else; include it once in any module that asserts.
`ifndef COLOR_SPACE_CONVERTER_MACROS_SVH
`define COLOR_SPACE_CONVERTER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("color_space_converter: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("color_space_converter: next-cycle check failed");

`endif

### rtl/csc_pkg.sv
// Types and fixed constants of the color space converter.
// No dependencies; imported by csc_row and color_space_converter.
package csc_pkg;

	typedef logic [7:0] pixel_t;
	typedef logic [1:0] mode_t;

	localparam mode_t MODE_RGB2YCC = 2'd0;
	localparam mode_t MODE_YCC2RGB = 2'd1;
	localparam mode_t MODE_YUV2RGB = 2'd2;

	localparam int OFFS_LUMA   = 16;
	localparam int OFFS_CHROMA = 128;

	// Load strobes for the register stages inside one row datapath.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} csc_adv_t;

endpackage

### rtl/color_space_converter.sv
// Color space converter top level: stream ports, mode register, stage control.
// Uses csc_pkg, csc_row and color_space_converter_macros.svh.
//
// Converts one pixel per clock between RGB and YCbCr: mode 0 gives studio-range
// BT.601 YCbCr from RGB, mode 1 full-range YCbCr to RGB, mode 2 (and 3) the YUV
// to RGB variant. Every pixel passes four register stages: an operand stage, a
// multiplier stage, a sum stage and the saturating output register. m_tvalid
// rises when the word reaches the output register and stays high until
// m_tready takes it. A new pixel is accepted every cycle as long as the
// pipeline has a free stage, so throughput is one pixel per clock until
// m_tready stalls and all four stages fill. Coefficients carry
// COEF_FRAC_BITS fraction bits; sums truncate toward zero and clamp to 0..255.
// Write the mode only while idle.
`include "color_space_converter_macros.svh"

module color_space_converter #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  csc_pkg::mode_t       cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // comp_a [7:0], comp_b [15:8], comp_c [23:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata    // out_a [7:0], out_b [15:8], out_c [23:16]
);
	import csc_pkg::*;

	localparam int F  = COEF_FRAC_BITS;
	localparam int CW = F + 3;
	localparam int SW = F + 12;

	localparam longint ONE = longint'(1) << F;

	localparam logic signed [CW-1:0] K_ONE  = CW'(ONE);
	localparam logic signed [CW-1:0] K_YR   = CW'((257 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_YG   = CW'((504 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_YB   = CW'((98 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_BR   = CW'(-((148 * ONE + 500) / 1000));
	localparam logic signed [CW-1:0] K_BG   = CW'(-((291 * ONE + 500) / 1000));
	localparam logic signed [CW-1:0] K_BB   = CW'((439 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_RR   = CW'((439 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_RG   = CW'(-((368 * ONE + 500) / 1000));
	localparam logic signed [CW-1:0] K_RB   = CW'(-((714 * ONE + 5000) / 10000));
	localparam logic signed [CW-1:0] K_F_RV = CW'((1402 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_F_GU = CW'(-((344 * ONE + 500) / 1000));
	localparam logic signed [CW-1:0] K_F_GV = CW'(-((714 * ONE + 500) / 1000));
	localparam logic signed [CW-1:0] K_F_BU = CW'((1772 * ONE + 500) / 1000);
	localparam logic signed [CW-1:0] K_V_RV = CW'((14075 * ONE + 5000) / 10000);
	localparam logic signed [CW-1:0] K_V_GU = CW'(-((3455 * ONE + 5000) / 10000));
	localparam logic signed [CW-1:0] K_V_GV = CW'(-((7169 * ONE + 5000) / 10000));
	localparam logic signed [CW-1:0] K_V_BU = CW'((1779 * ONE + 500) / 1000);

	localparam logic signed [SW-1:0] B_LUMA   = SW'(longint'(OFFS_LUMA) * ONE);
	localparam logic signed [SW-1:0] B_CHROMA = SW'(longint'(OFFS_CHROMA) * ONE);

	mode_t mode_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic s_fire, m_fire;

	mode_t             mode_s1;
	logic signed [8:0] x0_s1, x1_s1, x2_s1;

	logic signed [CW-1:0] k [3][3];
	logic signed [SW-1:0] base [3];

	csc_adv_t adv;
	pixel_t   pix [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_YCC2RGB;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// A stage takes a new word when it is empty or its word moves on.
	assign rdy4 = !valid_s4 || m_tready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign s_tready = rdy1;
	assign s_fire   = s_tvalid && rdy1;
	assign m_fire   = valid_s4 && m_tready;

	assign adv.ld_s2 = rdy2;
	assign adv.ld_s3 = rdy3;
	assign adv.ld_s4 = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// Operand stage: chroma inputs lose their 128 bias outside mode 0.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			mode_s1 <= mode_q;
			x0_s1   <= $signed({1'b0, s_tdata[7:0]});
			if (mode_q == MODE_RGB2YCC) begin
				x1_s1 <= $signed({1'b0, s_tdata[15:8]});
				x2_s1 <= $signed({1'b0, s_tdata[23:16]});
			end else begin
				x1_s1 <= $signed({1'b0, s_tdata[15:8]}) - 9'sd128;
				x2_s1 <= $signed({1'b0, s_tdata[23:16]}) - 9'sd128;
			end
		end
	end

	// Coefficient and offset selection feeding the multipliers.
	always_comb begin
		case (mode_s1)
			MODE_RGB2YCC: begin
				k[0][0] = K_YR; k[0][1] = K_YG; k[0][2] = K_YB;
				k[1][0] = K_BR; k[1][1] = K_BG; k[1][2] = K_BB;
				k[2][0] = K_RR; k[2][1] = K_RG; k[2][2] = K_RB;
				base[0] = B_LUMA;
				base[1] = B_CHROMA;
				base[2] = B_CHROMA;
			end
			MODE_YCC2RGB: begin
				k[0][0] = K_ONE; k[0][1] = '0;     k[0][2] = K_F_RV;
				k[1][0] = K_ONE; k[1][1] = K_F_GU; k[1][2] = K_F_GV;
				k[2][0] = K_ONE; k[2][1] = K_F_BU; k[2][2] = '0;
				base[0] = '0;
				base[1] = '0;
				base[2] = '0;
			end
			default: begin
				k[0][0] = K_ONE; k[0][1] = '0;     k[0][2] = K_V_RV;
				k[1][0] = K_ONE; k[1][1] = K_V_GU; k[1][2] = K_V_GV;
				k[2][0] = K_ONE; k[2][1] = K_V_BU; k[2][2] = '0;
				base[0] = '0;
				base[1] = '0;
				base[2] = '0;
			end
		endcase
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		csc_row #(
			.FRAC (F)
		) u_row (
			.clk  (clk),
			.adv  (adv),
			.x0   (x0_s1),
			.x1   (x1_s1),
			.x2   (x2_s1),
			.k0   (k[r][0]),
			.k1   (k[r][1]),
			.k2   (k[r][2]),
			.base (base[r]),
			.pix  (pix[r])
		);
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {pix[2], pix[1], pix[0]};

	`CSC_ASSERT_NEXT(a_occ_inc, clk, arst_n, s_fire && !m_fire,
		$countones({valid_s4, valid_s3, valid_s2, valid_s1}) ==
		$past($countones({valid_s4, valid_s3, valid_s2, valid_s1})) + 1)
	`CSC_ASSERT_NEXT(a_occ_dec, clk, arst_n, m_fire && !s_fire,
		$countones({valid_s4, valid_s3, valid_s2, valid_s1}) + 1 ==
		$past($countones({valid_s4, valid_s3, valid_s2, valid_s1})))
	`CSC_ASSERT_NOW(a_full_stall, clk, arst_n,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready, !s_tready)

endmodule

### rtl/csc_row.sv
// One output row of the converter: three products, a sum and saturation.
// Uses csc_pkg; stage strobes come from the color_space_converter control.
module csc_row #(
	parameter int FRAC = 16
) (
	input  logic                      clk,
	input  csc_pkg::csc_adv_t         adv,
	input  logic signed [8:0]         x0,
	input  logic signed [8:0]         x1,
	input  logic signed [8:0]         x2,
	input  logic signed [FRAC+2:0]    k0,
	input  logic signed [FRAC+2:0]    k1,
	input  logic signed [FRAC+2:0]    k2,
	input  logic signed [FRAC+11:0]   base,
	output csc_pkg::pixel_t           pix
);
	import csc_pkg::*;

	localparam int SW = FRAC + 12;

	logic signed [SW-1:0] p0_s2, p1_s2, p2_s2, base_s2;
	logic signed [SW-1:0] sum_s3;
	pixel_t               pix_s4;

	// Products widen to full sum width so no term overflows.
	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			p0_s2   <= SW'(x0) * SW'(k0);
			p1_s2   <= SW'(x1) * SW'(k1);
			p2_s2   <= SW'(x2) * SW'(k2);
			base_s2 <= base;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			sum_s3 <= p0_s2 + p1_s2 + p2_s2 + base_s2;
		end
	end

	// Any negative sum truncates to zero or below: clamp to 0.
	always_ff @(posedge clk) begin
		if (adv.ld_s4) begin
			if (sum_s3[SW-1]) begin
				pix_s4 <= '0;
			end else if (|sum_s3[SW-2:FRAC+8]) begin
				pix_s4 <= 8'hFF;
			end else begin
				pix_s4 <= sum_s3[FRAC+7:FRAC];
			end
		end
	end

	assign pix = pix_s4;

endmodule
